FILE: hdl/isoa_pkg.sv
// ============================================================================
// isoa_pkg: shared types and constants of the IMU sample conditioner
// Widths, divider reciprocals and pipeline stage indexes used by all files.
// ============================================================================
`default_nettype none

package isoa_pkg;

    localparam int WINDOW      = 5;
    localparam int CAL_SAMPLES = 100;

    localparam int SMP_W = 16;
    localparam int AXES  = 3;
    localparam int LANES = 2 * AXES;

    // Moving average: running sum of the window and division by WINDOW.
    localparam int HIST_N  = WINDOW - 1;
    localparam int WIN_W   = SMP_W + $clog2(WINDOW);
    localparam int WIN_S   = WIN_W - 1;
    localparam int WPROD_W = 2 * WIN_W;
    localparam logic [WIN_W-1:0] M_WIN = WIN_W'((1 << WIN_S) / WINDOW);

    // Rate scaling: 160/164 reduces to 40/41.
    localparam int RATE_NUM = 40;
    localparam int RATE_DEN = 41;
    localparam int RMAG_W   = SMP_W + 1;
    localparam int RATE_S   = RMAG_W;
    localparam int RPROD_W  = 2 * RMAG_W;
    localparam int RNUM_W   = RMAG_W + $clog2(RATE_NUM);
    localparam logic [RMAG_W-1:0] M_RATE = RMAG_W'((RATE_NUM << RATE_S) / RATE_DEN);

    // Gyro bias calibration.
    localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int CAL_W   = SMP_W + CNT_W;
    localparam int CAL_S   = CAL_W - 1;
    localparam int CPROD_W = 2 * CAL_W;
    localparam logic [CAL_W-1:0] M_CAL = CAL_W'((1 << CAL_S) / CAL_SAMPLES);

    // Pipeline stage indexes.
    localparam int ST_IN    = 1;
    localparam int ST_DLY   = 2;
    localparam int ST_WIN   = 3;
    localparam int ST_WPROD = 4;
    localparam int ST_AVG   = 5;
    localparam int ST_RPROD = 6;
    localparam int ST_RES   = 7;
    localparam int ST_OUT   = 8;
    localparam int NSTG     = ST_OUT;

    typedef logic signed [SMP_W-1:0] smp_t;

    typedef struct packed {
        logic [NSTG:1] adv;
        logic          app_dly;
        logic          app_res;
        logic          out_valid;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/isoa_if.sv
// ============================================================================
// isoa_if: sample and result channels of the IMU sample conditioner
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface isoa_in_if;
    import isoa_pkg::*;

    logic valid;
    logic ready;
    smp_t accel_x_raw;
    smp_t accel_y_raw;
    smp_t accel_z_raw;
    smp_t gyro_x_raw;
    smp_t gyro_y_raw;
    smp_t gyro_z_raw;

    modport source (
        output valid, accel_x_raw, accel_y_raw, accel_z_raw,
        output gyro_x_raw, gyro_y_raw, gyro_z_raw,
        input  ready
    );

    modport sink (
        input  valid, accel_x_raw, accel_y_raw, accel_z_raw,
        input  gyro_x_raw, gyro_y_raw, gyro_z_raw,
        output ready
    );
endinterface

interface isoa_out_if;
    import isoa_pkg::*;

    logic valid;
    logic ready;
    smp_t accel_x_avg;
    smp_t accel_y_avg;
    smp_t accel_z_avg;
    smp_t rate_x_q4;
    smp_t rate_y_q4;
    smp_t rate_z_q4;
    logic offset_ready;

    modport source (
        output valid, accel_x_avg, accel_y_avg, accel_z_avg,
        output rate_x_q4, rate_y_q4, rate_z_q4, offset_ready,
        input  ready
    );

    modport sink (
        input  valid, accel_x_avg, accel_y_avg, accel_z_avg,
        input  rate_x_q4, rate_y_q4, rate_z_q4, offset_ready,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/isoa_ctrl.sv
// ============================================================================
// isoa_ctrl: pipeline flow control
// Per-stage valid bits, backward ready chain and the bias-applied tag per beat.
// ============================================================================
`default_nettype none

module isoa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_ready,
    input  logic           cal_done,
    output logic           in_ready,
    output isoa_pkg::ctrl_t ctl
);
    import isoa_pkg::*;

    logic [NSTG:1]   v_reg;
    logic [NSTG:1]   v_next;
    logic [NSTG:1]   rdy;
    logic [NSTG:1]   adv;
    logic [NSTG:1]   lv;
    logic [NSTG-1:1] app_reg;
    logic [NSTG-1:1] app_next;

    always_comb
    begin
        rdy[NSTG] = !v_reg[NSTG] || out_ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        adv[1] = in_valid && rdy[1];
        for (int k = 2; k <= NSTG; k++)
        begin
            adv[k] = v_reg[k-1] && rdy[k];
        end
        for (int k = 1; k < NSTG; k++)
        begin
            lv[k] = adv[k+1];
        end
        lv[NSTG] = out_ready;
        for (int k = 1; k <= NSTG; k++)
        begin
            v_next[k] = adv[k] || (v_reg[k] && !lv[k]);
        end
        app_next[1] = adv[1] ? cal_done : app_reg[1];
        for (int k = 2; k < NSTG; k++)
        begin
            app_next[k] = adv[k] ? app_reg[k-1] : app_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            app_reg <= '0;
        end
        else
        begin
            v_reg   <= v_next;
            app_reg <= app_next;
        end
    end

    always_comb
    begin
        in_ready      = rdy[1];
        ctl.adv       = adv;
        ctl.app_dly   = app_reg[ST_DLY];
        ctl.app_res   = app_reg[ST_RES];
        ctl.out_valid = v_reg[NSTG];
    end

endmodule

`default_nettype wire

FILE: hdl/isoa_cal.sv
// ============================================================================
// isoa_cal: gyro bias calibration
// Sums the first calibration samples per axis and divides by a reciprocal.
// ============================================================================
`default_nettype none

module isoa_cal (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  isoa_pkg::smp_t [isoa_pkg::AXES-1:0] gyro,
    output logic                          done,
    output isoa_pkg::smp_t [isoa_pkg::AXES-1:0] bias
);
    import isoa_pkg::*;

    logic signed [CAL_W-1:0] sum_reg [AXES];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [CAL_W-1:0]        mag [AXES];
    logic [CAL_W-1:0]        cmag_reg [AXES];
    logic                    cneg_reg [AXES];
    logic [CPROD_W-1:0]      cprod_reg [AXES];
    logic [CAL_W-1:0]        q0 [AXES];
    logic [CAL_W-1:0]        rem [AXES];
    logic [CAL_W-1:0]        q [AXES];
    smp_t                    bias_next [AXES];
    smp_t [AXES-1:0]         bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (accept && !done_reg)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sum_reg[a] <= sum_reg[a] + CAL_W'(gyro[a]);
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CAL_SAMPLES - 1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // The divider runs every cycle; once the sums freeze, the bias settles
    // through the product register and then the bias register.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag[a] = sum_reg[a][CAL_W-1] ? CAL_W'(-sum_reg[a]) : CAL_W'(sum_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            cneg_reg[a]  <= sum_reg[a][CAL_W-1];
            cmag_reg[a]  <= mag[a];
            cprod_reg[a] <= CPROD_W'(mag[a]) * CPROD_W'(M_CAL);
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            q0[a]  = cprod_reg[a][CAL_S +: CAL_W];
            rem[a] = cmag_reg[a] - CAL_W'(q0[a] * CAL_SAMPLES);
            q[a]   = q0[a] + CAL_W'(rem[a] >= CAL_W'(CAL_SAMPLES));
            bias_next[a] = SMP_W'(cneg_reg[a] ? -q[a] : q[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            bias_reg[a] <= bias_next[a];
        end
    end

    assign done = done_reg;
    assign bias = bias_reg;

endmodule

`default_nettype wire

FILE: hdl/isoa_lane.sv
// ============================================================================
// isoa_lane: one axis of the conditioner
// Optional bias subtraction, moving average, division by the window length
// and, for gyro axes, scaling to deg/s in Q.4.
// ============================================================================
`default_nettype none

module isoa_lane (
    input  logic            clk,
    input  logic            rst_n,
    input  isoa_pkg::ctrl_t ctl,
    input  isoa_pkg::smp_t  sample,
    input  isoa_pkg::smp_t  bias,
    input  logic            gyro,
    output isoa_pkg::smp_t  result
);
    import isoa_pkg::*;

    smp_t                    s1_reg;
    smp_t                    s2_reg;
    smp_t                    corr;
    smp_t                    hist_reg [HIST_N];
    logic signed [WIN_W-1:0] run_sum_reg;
    logic signed [WIN_W-1:0] run_sum_next;
    logic signed [WIN_W-1:0] win_sum;
    logic signed [WIN_W-1:0] win3_reg;
    logic [WIN_W-1:0]        wmag;
    logic [WIN_W-1:0]        mag4_reg;
    logic                    neg4_reg;
    logic [WPROD_W-1:0]      prod4_reg;
    logic [WIN_W-1:0]        wq0;
    logic [WIN_W-1:0]        wrem;
    logic [WIN_W-1:0]        wq;
    smp_t                    avg5_reg;
    logic signed [RMAG_W-1:0] a17;
    logic [RMAG_W-1:0]       rmag;
    logic [RMAG_W-1:0]       mag6_reg;
    logic                    neg6_reg;
    logic [RPROD_W-1:0]      prod6_reg;
    smp_t                    avg6_reg;
    logic [RMAG_W-1:0]       rq0;
    logic [RNUM_W-1:0]       rnum;
    logic [RNUM_W-1:0]       rrem;
    logic [RMAG_W-1:0]       rq;
    smp_t                    rate;
    smp_t                    res7_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[ST_IN])
        begin
            s1_reg <= sample;
        end
        if (ctl.adv[ST_DLY])
        begin
            s2_reg <= s1_reg;
        end
    end

    always_comb
    begin
        corr         = (gyro && ctl.app_dly) ? SMP_W'(s2_reg - bias) : s2_reg;
        win_sum      = run_sum_reg + WIN_W'(corr);
        run_sum_next = win_sum - WIN_W'(hist_reg[HIST_N-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg <= '0;
            for (int i = 0; i < HIST_N; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.adv[ST_WIN])
        begin
            run_sum_reg <= run_sum_next;
            hist_reg[0] <= corr;
            for (int i = 1; i < HIST_N; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_comb
    begin
        wmag = win3_reg[WIN_W-1] ? WIN_W'(-win3_reg) : WIN_W'(win3_reg);
        wq0  = prod4_reg[WIN_S +: WIN_W];
        wrem = mag4_reg - WIN_W'(wq0 * WINDOW);
        wq   = wq0 + WIN_W'(wrem >= WIN_W'(WINDOW));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[ST_WIN])
        begin
            win3_reg <= win_sum;
        end
        if (ctl.adv[ST_WPROD])
        begin
            neg4_reg  <= win3_reg[WIN_W-1];
            mag4_reg  <= wmag;
            prod4_reg <= WPROD_W'(wmag) * WPROD_W'(M_WIN);
        end
        if (ctl.adv[ST_AVG])
        begin
            avg5_reg <= SMP_W'(neg4_reg ? -wq : wq);
        end
    end

    always_comb
    begin
        a17  = RMAG_W'(avg5_reg);
        rmag = avg5_reg[SMP_W-1] ? RMAG_W'(-a17) : RMAG_W'(a17);
        rq0  = prod6_reg[RATE_S +: RMAG_W];
        rnum = RNUM_W'(mag6_reg) * RNUM_W'(RATE_NUM);
        rrem = rnum - RNUM_W'(rq0) * RNUM_W'(RATE_DEN);
        rq   = rq0 + RMAG_W'(rrem >= RNUM_W'(RATE_DEN));
        rate = SMP_W'(neg6_reg ? -rq : rq);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[ST_RPROD])
        begin
            neg6_reg  <= avg5_reg[SMP_W-1];
            mag6_reg  <= rmag;
            prod6_reg <= RPROD_W'(rmag) * RPROD_W'(M_RATE);
            avg6_reg  <= avg5_reg;
        end
        if (ctl.adv[ST_RES])
        begin
            res7_reg <= gyro ? rate : avg6_reg;
        end
    end

    assign result = res7_reg;

endmodule

`default_nettype wire

FILE: hdl/isoa_merge.sv
// ============================================================================
// isoa_merge: result stage
// Gathers the six lane results and the bias flag into the output register.
// ============================================================================
`default_nettype none

module isoa_merge (
    input  logic                                 clk,
    input  isoa_pkg::ctrl_t                      ctl,
    input  isoa_pkg::smp_t [isoa_pkg::LANES-1:0] lane_res,
    isoa_out_if.source                           results
);
    import isoa_pkg::*;

    smp_t [LANES-1:0] res_reg;
    logic             ofs_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[ST_OUT])
        begin
            res_reg <= lane_res;
            ofs_reg <= ctl.app_res;
        end
    end

    assign results.valid        = ctl.out_valid;
    assign results.accel_x_avg  = res_reg[0];
    assign results.accel_y_avg  = res_reg[1];
    assign results.accel_z_avg  = res_reg[2];
    assign results.rate_x_q4    = res_reg[AXES];
    assign results.rate_y_q4    = res_reg[AXES+1];
    assign results.rate_z_q4    = res_reg[AXES+2];
    assign results.offset_ready = ofs_reg;

endmodule

`default_nettype wire

FILE: hdl/imu_sample_offset_and_average.sv
// ============================================================================
// imu_sample_offset_and_average: six-axis IMU sample conditioner
// Gyro bias calibration, per-axis moving average and gyro rate scaling.
// ============================================================================
// Six axis lanes run side by side through stages ST_IN to ST_OUT.
// Throughput: one sample beat per cycle unless results.ready stalls the pipe.
// The gyro sample waits two stages so the calibration divider has its bias
// ready for the beat that follows the last calibration sample.
// Reset clears window histories, calibration sums and count, and all valids;
// the first CAL_SAMPLES beats calibrate and leave offset_ready low.
`default_nettype none

module imu_sample_offset_and_average (
    input  logic      clk,
    input  logic      rst_n,
    isoa_in_if.sink   samples,
    isoa_out_if.source results
);
    import isoa_pkg::*;

    ctrl_t            ctl;
    logic             in_ready;
    logic             cal_done;
    smp_t [AXES-1:0]  gyro_raw;
    smp_t [AXES-1:0]  bias;
    smp_t [LANES-1:0] lane_in;
    smp_t [LANES-1:0] lane_bias;
    logic [LANES-1:0] lane_gyro;
    smp_t [LANES-1:0] lane_res;

    assign samples.ready = in_ready;

    assign gyro_raw[0] = samples.gyro_x_raw;
    assign gyro_raw[1] = samples.gyro_y_raw;
    assign gyro_raw[2] = samples.gyro_z_raw;

    assign lane_in[0]      = samples.accel_x_raw;
    assign lane_in[1]      = samples.accel_y_raw;
    assign lane_in[2]      = samples.accel_z_raw;
    assign lane_in[AXES]   = samples.gyro_x_raw;
    assign lane_in[AXES+1] = samples.gyro_y_raw;
    assign lane_in[AXES+2] = samples.gyro_z_raw;

    isoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .out_ready (results.ready),
        .cal_done  (cal_done),
        .in_ready  (in_ready),
        .ctl       (ctl)
    );

    isoa_cal u_cal (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (ctl.adv[ST_IN]),
        .gyro   (gyro_raw),
        .done   (cal_done),
        .bias   (bias)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        if (l < AXES)
        begin : g_acc
            assign lane_bias[l] = '0;
            assign lane_gyro[l] = 1'b0;
        end
        else
        begin : g_gyr
            assign lane_bias[l] = bias[l-AXES];
            assign lane_gyro[l] = 1'b1;
        end

        isoa_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (lane_in[l]),
            .bias   (lane_bias[l]),
            .gyro   (lane_gyro[l]),
            .result (lane_res[l])
        );
    end

    isoa_merge u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .lane_res (lane_res),
        .results  (results)
    );

    a_ofs_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.offset_ready |-> cal_done)
        else $error("offset_ready shown before calibration finished");

    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cal_done |=> cal_done)
        else $error("calibration done flag dropped");

    a_bias_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cal_done, 3) |-> $stable(bias))
        else $error("gyro bias changed after calibration");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.out_valid |-> samples.ready)
        else $error("input stalled with an empty output stage");

endmodule

`default_nettype wire

FILE: sim/isoa_result_checker.sv
// ============================================================================
// isoa_result_checker: result prediction and comparison for the IMU conditioner
// Watches the sample and result channels, predicts every result beat from the
// accepted sample beats and compares the two in order, counting mismatches.
// ============================================================================
`default_nettype none

module isoa_result_checker (
    input  logic clk,
    input  logic rst_n,
    isoa_in_if   smp,
    isoa_out_if  res,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   applied_seen
);
    import isoa_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int DPS_NUM      = 160;
    localparam int DPS_DEN      = 164;

    typedef struct packed {
        smp_t accel_x_avg;
        smp_t accel_y_avg;
        smp_t accel_z_avg;
        smp_t rate_x_q4;
        smp_t rate_y_q4;
        smp_t rate_z_q4;
        logic offset_ready;
    } conditioned_t;

    // Lanes 0 to 2 hold the accelerometer axes, lanes 3 to 5 the gyro axes.
    smp_t lane_history [LANES][HIST_N];
    int   cal_sum [AXES];
    int   cal_count;
    smp_t gyro_bias [AXES];
    logic bias_ok;

    conditioned_t conditioned_due [$];
    int mismatches;
    int checked;
    int applied;
    int queued;

    assign fail_count   = mismatches;
    assign pending      = queued;
    assign results_seen = checked;
    assign applied_seen = applied;

    function automatic conditioned_t condition_sample(input smp_t lane_in [LANES]);
        smp_t         lane [LANES];
        int           avg [LANES];
        int           sum;
        logic         was_applied;
        conditioned_t r;
        lane = lane_in;
        was_applied = bias_ok;
        if (was_applied)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                lane[AXES+a] = lane[AXES+a] - gyro_bias[a];
            end
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cal_sum[a] += lane[AXES+a];
            end
            cal_count++;
            if (cal_count >= CAL_SAMPLES)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    gyro_bias[a] = smp_t'(cal_sum[a] / CAL_SAMPLES);
                end
                bias_ok = 1'b1;
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            sum = lane[l];
            for (int i = 0; i < HIST_N; i++)
            begin
                sum += lane_history[l][i];
            end
            for (int i = HIST_N - 1; i > 0; i--)
            begin
                lane_history[l][i] = lane_history[l][i-1];
            end
            lane_history[l][0] = lane[l];
            avg[l] = sum / WINDOW;
        end
        for (int a = AXES; a < LANES; a++)
        begin
            avg[a] = (avg[a] * DPS_NUM) / DPS_DEN;
        end
        r.accel_x_avg  = smp_t'(avg[0]);
        r.accel_y_avg  = smp_t'(avg[1]);
        r.accel_z_avg  = smp_t'(avg[2]);
        r.rate_x_q4    = smp_t'(avg[3]);
        r.rate_y_q4    = smp_t'(avg[4]);
        r.rate_z_q4    = smp_t'(avg[5]);
        r.offset_ready = was_applied;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        smp_t         lane [LANES];
        conditioned_t got;
        conditioned_t want;
        if (!rst_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                for (int i = 0; i < HIST_N; i++)
                begin
                    lane_history[l][i] = '0;
                end
            end
            for (int a = 0; a < AXES; a++)
            begin
                cal_sum[a]   = 0;
                gyro_bias[a] = '0;
            end
            cal_count = 0;
            bias_ok   = 1'b0;
            conditioned_due.delete();
            queued = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = conditioned_t'{res.accel_x_avg, res.accel_y_avg, res.accel_z_avg,
                                     res.rate_x_q4, res.rate_y_q4, res.rate_z_q4,
                                     res.offset_ready};
                checked++;
                if (got.offset_ready === 1'b1)
                begin
                    applied++;
                end
                if (conditioned_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("result beat %0d arrived with no sample waiting for it",
                                 checked);
                    end
                end
                else
                begin
                    want = conditioned_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("result beat %0d expected: %0d %0d %0d | %0d %0d %0d | %b",
                                     checked, $signed(want.accel_x_avg),
                                     $signed(want.accel_y_avg), $signed(want.accel_z_avg),
                                     $signed(want.rate_x_q4), $signed(want.rate_y_q4),
                                     $signed(want.rate_z_q4), want.offset_ready);
                            $display("result beat %0d actual:   %0d %0d %0d | %0d %0d %0d | %b",
                                     checked, $signed(got.accel_x_avg),
                                     $signed(got.accel_y_avg), $signed(got.accel_z_avg),
                                     $signed(got.rate_x_q4), $signed(got.rate_y_q4),
                                     $signed(got.rate_z_q4), got.offset_ready);
                        end
                    end
                end
            end
            if (smp.valid && smp.ready)
            begin
                lane[0] = smp.accel_x_raw;
                lane[1] = smp.accel_y_raw;
                lane[2] = smp.accel_z_raw;
                lane[3] = smp.gyro_x_raw;
                lane[4] = smp.gyro_y_raw;
                lane[5] = smp.gyro_z_raw;
                conditioned_due.push_back(condition_sample(lane));
            end
            queued = conditioned_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ============================================================================
// tb_top: testbench of the IMU sample conditioner
// Drives raw six-axis sample beats through gyro calibration and filtering,
// with bursty input, a stalling receiver and one long hold-off, and reports
// the verdict from the result checker.
// ============================================================================
`default_nettype none

module tb_top;
    import isoa_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 336;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AT      = 260;
    localparam int NOGAP_FIRST  = 250;
    localparam int NOGAP_LAST   = 330;
    localparam int PAUSE_AT     = 400;

    typedef enum int {RX_OPEN, RX_JITTER, RX_BLOCK} rx_mode_t;

    typedef struct packed {
        smp_t ax;
        smp_t ay;
        smp_t az;
        smp_t gx;
        smp_t gy;
        smp_t gz;
    } raw_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    isoa_in_if  smp_ch ();
    isoa_out_if res_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int applied_seen;

    int sent;
    int burst_left;
    bit hold_req;

    imu_sample_offset_and_average i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp_ch),
        .results (res_ch)
    );

    isoa_result_checker i_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .smp          (smp_ch),
        .res          (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .applied_seen (applied_seen)
    );

    always #CLK_HALF clk = ~clk;

    function automatic raw_sample_t uniform(input smp_t v);
        return raw_sample_t'{v, v, v, v, v, v};
    endfunction

    function automatic smp_t pick_value();
        case ($urandom_range(0, 7))
            0:       return smp_t'(16'h7FFF);
            1:       return smp_t'(16'h8000);
            2, 3:    return smp_t'(int'($urandom_range(0, 64)) - 32);
            default: return smp_t'($urandom());
        endcase
    endfunction

    function automatic raw_sample_t random_sample();
        return raw_sample_t'{pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value(), pick_value()};
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic drive_sample(input raw_sample_t s, input bit steady);
        int gap;
        if (!steady && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                smp_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        smp_ch.valid       <= 1'b1;
        smp_ch.accel_x_raw <= s.ax;
        smp_ch.accel_y_raw <= s.ay;
        smp_ch.accel_z_raw <= s.az;
        smp_ch.gyro_x_raw  <= s.gx;
        smp_ch.gyro_y_raw  <= s.gy;
        smp_ch.gyro_z_raw  <= s.gz;
        @(posedge clk);
        while (!smp_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
        @(negedge clk);
    endtask

    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        logic     rdy;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        mode = RX_OPEN;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = (mode == RX_BLOCK) ? $urandom_range(1, 5)
                                                   : $urandom_range(1, 30);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_JITTER: rdy = ($urandom_range(0, 3) != 0);
                    default:   rdy = 1'b0;
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        raw_sample_t s;
        sent       = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        rst_n              = 1'b0;
        smp_ch.valid       = 1'b0;
        smp_ch.accel_x_raw = '0;
        smp_ch.accel_y_raw = '0;
        smp_ch.accel_z_raw = '0;
        smp_ch.gyro_x_raw  = '0;
        smp_ch.gyro_y_raw  = '0;
        smp_ch.gyro_z_raw  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first samples calibrate and also start the windows from zero.
        drive_sample(uniform(smp_t'(0)), 1'b0);
        drive_sample(uniform(smp_t'(16'h7FFF)), 1'b0);
        drive_sample(uniform(smp_t'(16'h8000)), 1'b0);
        drive_sample(raw_sample_t'{smp_t'(16'h7FFF), smp_t'(16'h8000), smp_t'(16'h7FFF),
                                   smp_t'(16'h7FFF), smp_t'(16'h8000), smp_t'(16'h7FFF)},
                     1'b0);
        drive_sample(uniform(smp_t'(16'h5555)), 1'b0);
        drive_sample(uniform(smp_t'(16'hAAAA)), 1'b0);
        drive_sample(uniform(smp_t'(-1)), 1'b0);
        drive_sample(uniform(smp_t'(1)), 1'b0);

        // A strongly positive x bias and negative y bias make the later
        // subtraction wrap at both ends.
        while (sent < CAL_SAMPLES)
        begin
            s = random_sample();
            s.gx = smp_t'($urandom_range(20000, 32767));
            s.gy = smp_t'(-int'($urandom_range(20000, 32768)));
            drive_sample(s, 1'b0);
        end

        drive_sample(uniform(smp_t'(16'h8000)), 1'b0);
        drive_sample(uniform(smp_t'(16'h7FFF)), 1'b0);
        drive_sample(uniform(smp_t'(0)), 1'b0);
        drive_sample(raw_sample_t'{smp_t'(0), smp_t'(0), smp_t'(0),
                                   smp_t'(16'h8000), smp_t'(16'h7FFF), smp_t'(16'h8000)},
                     1'b0);
        drive_sample(raw_sample_t'{smp_t'(0), smp_t'(0), smp_t'(0),
                                   smp_t'(16'h7FFF), smp_t'(16'h8000), smp_t'(16'h7FFF)},
                     1'b0);
        drive_sample(uniform(smp_t'(-1)), 1'b0);
        drive_sample(uniform(smp_t'(16'h5555)), 1'b0);
        drive_sample(uniform(smp_t'(16'hAAAA)), 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (sent == HOLD_AT)
            begin
                hold_req = 1'b1;
            end
            if (sent == PAUSE_AT)
            begin
                smp_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                begin
                    @(negedge clk);
                end
            end
            drive_sample(random_sample(), (sent >= NOGAP_FIRST) && (sent < NOGAP_LAST));
        end

        smp_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d sample beats, the first %0d of them calibrating the gyro bias.",
                 sent, CAL_SAMPLES);
        $display("Checked %0d result beats, %0d with the bias applied; %0d mismatches.",
                 results_seen, applied_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
